>>> rtl/core/brb_pkg.sv
`default_nettype none

package brb_pkg;

    // Default storage limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Stream word widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    // Position-derived decision flags, computed when an item is taken
    typedef struct packed {
        logic res_c2;     // row-end result (pixel in last column of older row)
        logic last_c2;
        logic top_c2;
        logic bot_c2;
        logic res_c1;     // in-row result (pixel one column back)
        logic last_c1;
        logic top_c1;
        logic bot_c1;
        logic left_c1;
        logic mid_c1;
        logic right_c1;
        logic border_c1;
        logic w_ge2;
        logic w_ge3;
    } t_pos_flags;

    // One result word
    typedef struct packed {
        logic frame_last;
        logic edge_res;
    } t_result;

    // Top-level control
    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_ctl_state;

endpackage

`default_nettype wire

>>> rtl/core/brb_ram.sv
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port
module brb_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/brb_edge_unit.sv
`default_nettype none

// 3x3 window register and boundary decision
module brb_edge_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_pix,
    input  wire logic [1:0]          i_stored,
    input  wire brb_pkg::t_pos_flags i_flags,
    output logic      [1:0]          o_wr_data,
    output logic                     o_res_valid,
    output brb_pkg::t_result         o_res
);

    logic [8:0] r_win;
    logic [8:0] n_win;
    logic [2:0] n_newcol;
    logic [8:0] n_mask_c2;
    logic [8:0] n_mask_c1;
    logic [2:0] n_col_c2;
    logic [2:0] n_row_c2;
    logic [2:0] n_col_c1;
    logic [2:0] n_row_c1;
    logic       n_edge_c2;
    logic       n_edge_c1;

    // New column: top = two rows back, middle = one row back, bottom = this row
    assign n_newcol  = {i_pix, i_stored[0], i_stored[1]};
    assign n_win     = {n_newcol, r_win[8:3]};
    assign o_wr_data = {i_stored[0], i_pix};

    // Neighbor masks, bit 3*col+row
    assign n_col_c2 = {1'b1, i_flags.w_ge2, i_flags.w_ge3};
    assign n_row_c2 = {i_flags.bot_c2, 1'b1, i_flags.top_c2};
    assign n_col_c1 = {i_flags.right_c1, i_flags.mid_c1, i_flags.left_c1};
    assign n_row_c1 = {i_flags.bot_c1, 1'b1, i_flags.top_c1};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_mask_c2[3*k+j] = n_col_c2[k] & n_row_c2[j];
                n_mask_c1[3*k+j] = n_col_c1[k] & n_row_c1[j];
            end
        end
    end

    // Row-end result uses the window before the shift, centre in the right column;
    // a centre in the last column is always on the border
    assign n_edge_c2 = r_win[7] | (|(r_win & n_mask_c2));
    assign n_edge_c1 = n_win[4] ? i_flags.border_c1 : (|(n_win & n_mask_c1));

    always_comb begin
        o_res_valid = i_valid & (i_flags.res_c2 | i_flags.res_c1);
        if (i_flags.res_c1) begin
            o_res.edge_res   = n_edge_c1;
            o_res.frame_last = i_flags.last_c1;
        end else begin
            o_res.edge_res   = n_edge_c2;
            o_res.frame_last = i_flags.last_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_valid) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/brb_out_queue.sv
`default_nettype none

// Two-word output queue; head drives the master side
module brb_out_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire brb_pkg::t_result  i_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output brb_pkg::t_result       o_data,
    output logic [1:0]             o_count
);

    brb_pkg::t_result r_q [2];
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             n_pop;
    logic [1:0]       n_slot;

    assign n_pop   = i_pop & (r_count != 2'd0);
    assign n_count = r_count + {1'b0, i_push} - {1'b0, n_pop};
    assign n_slot  = r_count - {1'b0, n_pop};
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[0];
    assign o_count = r_count;

    // Payload: shift on pop, write behind the remaining word
    always_ff @(posedge i_clk) begin
        if (i_push && (n_slot == 2'd0)) begin
            r_q[0] <= i_data;
        end else if (n_pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && (n_slot != 2'd0)) begin
            r_q[1] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/binary_region_boundary_3x3.sv
// Outer boundary of a binary mask over a 3x3 window, raster order.
// Slave stream: one mask pixel per word, tdata[0] = foreground, tuser[0] = flush
// (padding word after a frame). Master stream: tdata[0] = edge flag, tlast marks
// the result for the frame's last pixel.
// A frame is W*H pixel words followed by W+1 flush words; the result for a pixel
// leaves with the word one row plus one column later, none for flush-only slots.
// Throughput: one word per clock while the output queue has room. A word
// taken is registered with its row store read, then its decision goes into
// the output queue, whose head drives the master side.
// The row store is a one-port-read, one-port-write RAM of MAX_WIDTH x 2 bits;
// a same-address read right behind a write is served by a forward register.
// Reset: size registers return to 640 x 480, then the row store is cleared, one
// entry per clock over all MAX_WIDTH entries; s_axis_tready stays low meanwhile.
// Stall: results wait in a two-word queue; s_axis_tready drops only when that
// queue plus the word in flight could not absorb another result.
// Configuration (i_cfg_we/i_cfg_idx/i_cfg_data) is written by the user while idle
// only, unchecked; index 0 = width, 1 = height, clamped to 1..MAX_WIDTH/HEIGHT.
`default_nettype none

module binary_region_boundary_3x3 #(
    parameter int MAX_WIDTH  = brb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = brb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write
    input  wire logic                          i_cfg_we,
    input  wire logic [brb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [brb_pkg::CFG_W-1:0]     i_cfg_data,
    // slave stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [brb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [0] foreground
    input  wire logic [brb_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [0] flush
    // master stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [brb_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [0] edge_res
    output logic                               m_axis_tlast
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int MX1 = (AW > WW) ? AW : WW;
    localparam int MX2 = (MX1 > RW) ? MX1 : RW;
    localparam int CW  = MX2 + 1;

    localparam logic [WW-1:0] W_RST =
        WW'((brb_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : brb_pkg::WIDTH_RESET);
    localparam logic [HW-1:0] H_RST =
        HW'((brb_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : brb_pkg::HEIGHT_RESET);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_WIDTH - 1);

    // ---------------------------------------------------------------
    // Signals
    // ---------------------------------------------------------------
    brb_pkg::t_ctl_state r_state;
    logic [AW-1:0]       r_clr_addr;

    logic [WW-1:0]       r_img_w;
    logic [HW-1:0]       r_img_h;

    logic [AW-1:0]       r_ic;
    logic [RW-1:0]       r_ir;
    logic [AW-1:0]       n_ic;
    logic [RW-1:0]       n_ir;

    logic [CW-1:0]       n_icx;
    logic [CW-1:0]       n_irx;
    logic [CW-1:0]       n_wx;
    logic [CW-1:0]       n_hx;

    logic                n_accept;
    logic                n_pix;
    brb_pkg::t_pos_flags n_flags;

    logic                r_s1_valid;
    logic                r_s1_pix;
    logic [AW-1:0]       r_s1_addr;
    brb_pkg::t_pos_flags r_s1_flags;
    logic                r_fwd;
    logic [1:0]          r_fwd_data;

    logic [1:0]          n_ram_rdata;
    logic [1:0]          n_stored;
    logic [1:0]          n_wr_data;
    logic                n_ram_we;
    logic [AW-1:0]       n_ram_waddr;
    logic [1:0]          n_ram_wdata;

    logic                n_res_valid;
    brb_pkg::t_result    n_res;
    logic                n_q_valid;
    brb_pkg::t_result    n_q_data;
    logic [1:0]          n_q_count;
    logic                n_pop;

    // ---------------------------------------------------------------
    // Configuration registers, clamped on write
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= W_RST;
            r_img_h <= H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                brb_pkg::REG_IMAGE_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_img_w <= WW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                        r_img_w <= WW'(MAX_WIDTH);
                    end else begin
                        r_img_w <= WW'(i_cfg_data);
                    end
                end
                brb_pkg::REG_IMAGE_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_img_h <= HW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                        r_img_h <= HW'(MAX_HEIGHT);
                    end else begin
                        r_img_h <= HW'(i_cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Row store clear after reset
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= brb_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                brb_pkg::ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == CLR_LAST) begin
                        r_state <= brb_pkg::ST_RUN;
                    end
                end
                brb_pkg::ST_RUN: begin
                    r_state <= brb_pkg::ST_RUN;
                end
                default: begin
                    r_state <= brb_pkg::ST_CLEAR;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input handshake: room for the word in flight plus one more
    // ---------------------------------------------------------------
    assign n_pop = n_q_valid & m_axis_tready;

    always_comb begin
        case (n_q_count)
            2'd0:    s_axis_tready = 1'b1;
            2'd1:    s_axis_tready = !r_s1_valid || n_pop;
            default: s_axis_tready = !r_s1_valid && n_pop;
        endcase
        if (r_state != brb_pkg::ST_RUN) begin
            s_axis_tready = 1'b0;
        end
    end

    assign n_accept = s_axis_tvalid & s_axis_tready;

    // ---------------------------------------------------------------
    // Position counters and per-word flags
    // ---------------------------------------------------------------
    assign n_icx = CW'(r_ic);
    assign n_irx = CW'(r_ir);
    assign n_wx  = CW'(r_img_w);
    assign n_hx  = CW'(r_img_h);

    assign n_pix = (n_irx < n_hx) & s_axis_tdata[0] & ~s_axis_tuser[0];

    always_comb begin
        n_flags.res_c2    = (r_ic == '0) && (n_irx >= CW'(2)) && (n_irx < n_hx + CW'(2));
        n_flags.last_c2   = (n_irx == n_hx + CW'(1));
        n_flags.top_c2    = (n_irx >= CW'(3));
        n_flags.bot_c2    = (n_irx < n_hx + CW'(1));
        n_flags.res_c1    = (r_ic != '0) && (n_irx >= CW'(1)) && (n_irx < n_hx + CW'(1));
        n_flags.last_c1   = (n_irx == n_hx) && (n_icx == n_wx);
        n_flags.top_c1    = (n_irx >= CW'(2));
        n_flags.bot_c1    = (n_irx < n_hx);
        n_flags.left_c1   = (n_icx >= CW'(2)) && (n_icx < n_wx + CW'(2));
        n_flags.mid_c1    = (n_icx <= n_wx);
        n_flags.right_c1  = (n_icx < n_wx);
        n_flags.border_c1 = (n_irx == CW'(1)) || (n_irx == n_hx) ||
                            (n_icx == CW'(1)) || (n_icx == n_wx);
        n_flags.w_ge2     = (n_wx >= CW'(2));
        n_flags.w_ge3     = (n_wx >= CW'(3));
    end

    always_comb begin
        if (n_irx >= n_hx + CW'(1)) begin
            n_ic = '0;
            n_ir = '0;
        end else if (n_icx + CW'(1) >= n_wx) begin
            n_ic = '0;
            n_ir = r_ir + RW'(1);
        end else begin
            n_ic = r_ic + AW'(1);
            n_ir = r_ir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic <= '0;
            r_ir <= '0;
        end else if (n_accept) begin
            r_ic <= n_ic;
            r_ir <= n_ir;
        end
    end

    // ---------------------------------------------------------------
    // Decision stage register, forward on same-address overlap
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= n_accept;
            r_fwd      <= n_accept && r_s1_valid && (r_s1_addr == r_ic);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_s1_pix   <= n_pix;
            r_s1_addr  <= r_ic;
            r_s1_flags <= n_flags;
        end
        r_fwd_data <= n_wr_data;
    end

    assign n_stored = r_fwd ? r_fwd_data : n_ram_rdata;

    // ---------------------------------------------------------------
    // Row store
    // ---------------------------------------------------------------
    always_comb begin
        if (r_state == brb_pkg::ST_CLEAR) begin
            n_ram_we    = 1'b1;
            n_ram_waddr = r_clr_addr;
            n_ram_wdata = '0;
        end else begin
            n_ram_we    = r_s1_valid;
            n_ram_waddr = r_s1_addr;
            n_ram_wdata = n_wr_data;
        end
    end

    brb_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (n_ram_we),
        .i_waddr (n_ram_waddr),
        .i_wdata (n_ram_wdata),
        .i_re    (n_accept),
        .i_raddr (r_ic),
        .o_rdata (n_ram_rdata)
    );

    brb_edge_unit u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_pix       (r_s1_pix),
        .i_stored    (n_stored),
        .i_flags     (r_s1_flags),
        .o_wr_data   (n_wr_data),
        .o_res_valid (n_res_valid),
        .o_res       (n_res)
    );

    brb_out_queue u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_res_valid),
        .i_data  (n_res),
        .i_pop   (n_pop),
        .o_valid (n_q_valid),
        .o_data  (n_q_data),
        .o_count (n_q_count)
    );

    assign m_axis_tvalid = n_q_valid;
    assign m_axis_tdata  = {{(brb_pkg::M_TDATA_W-1){1'b0}}, n_q_data.edge_res};
    assign m_axis_tlast  = n_q_data.frame_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |-> (r_state == brb_pkg::ST_RUN))
        else $error("word taken during row store clear");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(n_res_valid && (n_q_count == 2'd2) && !n_pop))
        else $error("result pushed into full output queue");

    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (r_s1_valid && $past(r_s1_valid)))
        else $error("forward without an overlapping write");

    a_valid_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_res_valid |-> $past(n_accept))
        else $error("result without a word in the decision stage");

endmodule

`default_nettype wire

>>> sim/brb_boundary_checker.sv
`timescale 1ns / 100ps

// Scoreboard for the 3x3 boundary block: follows the config port and both
// stream channels, models the raster pipeline word by word and compares each
// result word against the oldest predicted one.
module brb_boundary_checker #(
    parameter int MAX_W = brb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_H = brb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [brb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [brb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [brb_pkg::S_TDATA_W-1:0] i_s_tdata,   // [0] foreground
    input  logic [brb_pkg::S_TUSER_W-1:0] i_s_tuser,   // [0] flush
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [brb_pkg::M_TDATA_W-1:0] i_m_tdata,   // [0] edge_res
    input  logic                          i_m_tlast,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output logic                          o_frame_start
);

    // Model state
    logic [1:0]               line_mem [MAX_W];
    logic [8:0]               win_bits;
    int                       col_pos;
    int                       row_pos;
    logic [brb_pkg::CFG_W-1:0] width_reg;
    logic [brb_pkg::CFG_W-1:0] height_reg;

    // Predicted boundary results, oldest first
    brb_pkg::t_result pending_edges [$];
    brb_pkg::t_result want_res;
    brb_pkg::t_result got_res;
    int fails   = 0;
    int results = 0;

    // Size as the block uses it: zero counts as one, too large saturates
    function automatic int used_dim(input logic [brb_pkg::CFG_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // Boundary decision for the center at window column ccol, image (cr, cc)
    function automatic logic boundary_of(input logic [8:0] w9, input int cr, input int cc,
                                         input int ccol, input int wd, input int ht);
        int r;
        int c;
        if (w9[ccol*3+1])
            return (cr == 0 || cr == ht - 1 || cc == 0 || cc == wd - 1);
        // background: any in-image neighbor set makes it an outer edge
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r = cr + j - 1;
                c = cc + k - ccol;
                if (r >= 0 && r < ht && c >= 0 && c < wd && w9[k*3+j])
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the raster by one accepted word, queue the result it releases
    task automatic take_mask_word(input logic fg, input logic fl);
        int wd;
        int ht;
        int ir;
        int ic;
        logic pix;
        logic [1:0] stored;
        logic [2:0] newcol;
        brb_pkg::t_result res;
        wd = used_dim(width_reg, MAX_W);
        ht = used_dim(height_reg, MAX_H);
        ir = row_pos;
        ic = col_pos;
        pix = (ir < ht) ? (fg & ~fl) : 1'b0;
        stored = (ic < MAX_W) ? line_mem[ic] : 2'b00;
        newcol = {pix, stored[0], stored[1]};

        // column 0 closes the last pixel of the row two back
        if (ic == 0 && ir >= 2 && ir - 2 < ht) begin
            res.edge_res   = boundary_of(win_bits, ir - 2, wd - 1, 2, wd, ht);
            res.frame_last = (ir - 2 == ht - 1);
            pending_edges = {pending_edges, res};
        end

        if (ic < MAX_W)
            line_mem[ic] = {stored[0], pix};
        win_bits = {newcol, win_bits[8:3]};

        // otherwise the pixel one row up and one column back
        if (ic >= 1 && ir >= 1 && ir - 1 < ht) begin
            res.edge_res   = boundary_of(win_bits, ir - 1, ic - 1, 1, wd, ht);
            res.frame_last = (ir - 1 == ht - 1) && (ic - 1 == wd - 1);
            pending_edges = {pending_edges, res};
        end

        // position counter, wraps back to the frame start after the flush
        if (ir >= ht + 1) begin
            row_pos = 0;
            col_pos = 0;
        end else if (ic + 1 >= wd) begin
            col_pos = 0;
            row_pos = ir + 1;
        end else begin
            col_pos = ic + 1;
        end
    endtask

    task automatic report_field(input string field, input logic exp_v, input logic act_v);
        fails++;
        if (fails <= 200)
            $display("%0t: %s mismatch, expected %b, got %b", $time, field, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = brb_pkg::WIDTH_RESET;
            height_reg = brb_pkg::HEIGHT_RESET;
            for (int i = 0; i < MAX_W; i++)
                line_mem[i] = 2'b00;
            win_bits = '0;
            col_pos  = 0;
            row_pos  = 0;
            pending_edges.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    brb_pkg::REG_IMAGE_WIDTH:  width_reg  = i_cfg_data;
                    brb_pkg::REG_IMAGE_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end

            // result word against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                results++;
                got_res.edge_res   = i_m_tdata[0];
                got_res.frame_last = i_m_tlast;
                if (pending_edges.size() == 0) begin
                    fails++;
                    if (fails <= 200)
                        $display("%0t: result word with none expected, got edge %b last %b",
                                 $time, got_res.edge_res, got_res.frame_last);
                end else begin
                    want_res = pending_edges.pop_front();
                    if (got_res.edge_res !== want_res.edge_res)
                        report_field("edge_res", want_res.edge_res, got_res.edge_res);
                    if (got_res.frame_last !== want_res.frame_last)
                        report_field("frame_last", want_res.frame_last, got_res.frame_last);
                end
            end

            if (i_s_tvalid && i_s_tready)
                take_mask_word(i_s_tdata[0], i_s_tuser[0]);
        end

        o_fail_count   <= fails;
        o_pending      <= pending_edges.size();
        o_result_count <= results;
        o_frame_start  <= (col_pos == 0 && row_pos == 0);
    end

endmodule

>>> sim/binary_region_boundary_3x3_test.sv
`timescale 1ns / 100ps

module binary_region_boundary_3x3_test;

    localparam int LIMIT_CYCLES = 300000;
    localparam int FULL_FRAME   = 1 << 30;

    // indexes with no register behind them
    localparam logic [brb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [brb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    // Directed words on a 4x3 frame, first word in bit 0: three foreground
    // corners, flush inside the pixel rows, a pixel inside the flush, an extra
    // flush word that opens the next frame, then five more of that frame's words.
    localparam logic [22:0] DIR_FG = 23'b01011100110100001101001;
    localparam logic [22:0] DIR_FL = 23'b00000111101000000100000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [brb_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [brb_pkg::CFG_W-1:0]     i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [brb_pkg::S_TDATA_W-1:0] s_axis_tdata;   // [0] foreground
    logic [brb_pkg::S_TUSER_W-1:0] s_axis_tuser;   // [0] flush
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [brb_pkg::M_TDATA_W-1:0] m_axis_tdata;   // [0] edge_res
    logic                          m_axis_tlast;

    int   fail_count;
    int   pending_results;
    int   result_count;
    logic frame_start;

    int   src_idle_pct  = 0;
    int   snk_idle_pct  = 0;
    int   words_sent    = 0;
    int   size_settings = 0;
    int   cur_w         = brb_pkg::WIDTH_RESET;
    int   cur_h         = brb_pkg::HEIGHT_RESET;
    bit   aligned       = 1'b1;
    int   cycles        = 0;

    binary_region_boundary_3x3 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    brb_boundary_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_m_tlast      (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_result_count (result_count),
        .o_frame_start  (frame_start)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("%0t: run stopped after %0d cycles, %0d results still due",
                     $time, cycles, pending_results);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int clamp_dim(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // One mask word, with random gaps ahead of it
    task automatic push_word(input logic fg, input logic fl);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= brb_pkg::S_TDATA_W'(fg);
        s_axis_tuser  <= brb_pkg::S_TUSER_W'(fl);
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        words_sent++;
    endtask

    // Hold off until every predicted result is out and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Leaves i_cfg_we high; the caller lowers it after its last write
    task automatic write_reg(input logic [brb_pkg::CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= brb_pkg::CFG_W'(val);
        @(posedge i_clk);
    endtask

    task automatic set_size(input int wd, input int ht);
        settle();
        write_reg(brb_pkg::REG_IMAGE_WIDTH, wd);
        write_reg(brb_pkg::REG_IMAGE_HEIGHT, ht);
        i_cfg_we <= 1'b0;
        cur_w = wd;
        cur_h = ht;
        size_settings++;
    endtask

    // Pad with flush words until the raster is back at the frame start
    task automatic sync_to_frame();
        settle();
        while (!frame_start) begin
            push_word(1'($urandom_range(0, 1)), 1'b1);
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        aligned = 1'b1;
    endtask

    // W*H pixels then W+1 flush words; err_pct flips the flush flag at random
    task automatic send_frame(input int err_pct, input int cut);
        int wd;
        int ht;
        int total;
        int density;
        logic fg;
        logic fl;
        wd = clamp_dim(cur_w, brb_pkg::MAX_WIDTH_DEF);
        ht = clamp_dim(cur_h, brb_pkg::MAX_HEIGHT_DEF);
        total = wd * ht + wd + 1;
        density = $urandom_range(0, 100);
        for (int k = 0; k < total && k < cut; k++) begin
            fg = ($urandom_range(0, 99) < density);
            fl = (k >= wd * ht);
            if ($urandom_range(0, 99) < err_pct)
                fl = ~fl;
            push_word(fg, fl);
        end
    endtask

    // Mostly clean frames with random content, some noise and cut frames
    task automatic run_random(input int n_words);
        int stop_at;
        int kind;
        int wd;
        int ht;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            // new size now and then, sometimes in the middle of a frame
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 2) != 0) begin
                    if (!aligned)
                        sync_to_frame();
                end else begin
                    aligned = 1'b0;
                end
                wd = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
                ht = $urandom_range(0, 8);
                set_size(wd, ht);
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 20))
                    push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                aligned = 1'b0;
            end else begin
                if (!aligned)
                    sync_to_frame();
                if (kind == 1) begin
                    send_frame(10, $urandom_range(1, 400));
                    aligned = 1'b0;
                end else begin
                    send_frame(0, FULL_FRAME);
                end
            end
        end
    endtask

    initial begin
        int waited;
        int leftover;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        src_idle_pct = 26;
        snk_idle_pct = 45;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // row store clear pass
        while (!s_axis_tready)
            @(posedge i_clk);

        // directed frame and its corner cases
        set_size(4, 3);
        for (int k = 0; k < 23; k++)
            push_word(DIR_FG[k], DIR_FL[k]);
        settle();
        write_reg(REG_UNMAPPED_2, 11'h7FF);
        write_reg(REG_UNMAPPED_3, 11'h2AA);
        i_cfg_we <= 1'b0;
        // raster sits at column 2, past the new width
        set_size(2, 3);
        aligned = 1'b0;

        run_random(170);

        src_idle_pct = 45;
        snk_idle_pct = 26;
        run_random(170);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(160);

        // zero size registers count as a single pixel
        if (!aligned)
            sync_to_frame();
        set_size(0, 0);
        send_frame(0, FULL_FRAME);
        s_axis_tvalid <= 1'b0;

        // drain
        waited = 0;
        while (pending_results != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        leftover = pending_results;
        if (leftover != 0)
            $display("%0t: %0d expected results never arrived", $time, leftover);

        $display("Sent %0d mask words over %0d frame sizes, clamped and mid-frame ones included,",
                 words_sent, size_settings);
        $display("and checked %0d result words under three source/sink pacing mixes.",
                 result_count);
        if (fail_count == 0 && leftover == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
